### rtl/core/fifo_free_block_allocator_top_defines.svh
// Assertion macros used by the allocator back end.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef FIFO_FREE_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIFO_FREE_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define FBA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FBA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/fba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fba_pkg;

   // field widths of the channel words
   localparam int IDX_W  = 10;
   localparam int CNT_W  = 7;
   localparam int STAT_W = 2;
   localparam int TOT_W  = 11;

   // defaults for the top-level parameters
   localparam int NUM_BLOCKS_DEF  = 1024;
   localparam int MAX_REQUEST_DEF = 64;

   // request function codes
   localparam logic FUNC_ALLOC   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   // result status codes
   localparam logic [STAT_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_SHORT       = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_BAD_RELEASE = 2'd2;

   // command class decided by the front end
   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_SHORT  = 2'd1,
      CMD_REL    = 2'd2,
      CMD_BADREL = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CNT_W-1:0]  count;
      logic [IDX_W-1:0]  idx;
   } cmd_type;

   // head of the command queue as seen by the back end
   typedef struct packed {
      logic    vld;
      cmd_type cmd;
   } q_head_type;

endpackage

`default_nettype wire

### rtl/core/fba_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface fba_req_if;
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [fba_pkg::CNT_W-1:0] req_count;
   logic [fba_pkg::IDX_W-1:0] free_index;
   logic                      free_last;

   modport source (output valid, func, req_count, free_index, free_last, input ready);
   modport sink   (input valid, func, req_count, free_index, free_last, output ready);
endinterface

// response channel
interface fba_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [fba_pkg::IDX_W-1:0]  block_index;
   logic [fba_pkg::STAT_W-1:0] status;
   logic                       run_last;
   logic [fba_pkg::TOT_W-1:0]  free_total;

   modport source (output valid, block_index, status, run_last, free_total, input ready);
   modport sink   (input valid, block_index, status, run_last, free_total, output ready);
endinterface

`default_nettype wire

### rtl/core/fifo_free_block_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake      Word
// req_if    in   valid/ready    func, req_count, free_index, free_last
// rsp_if    out  valid/ready    block_index, status, run_last, free_total
//
// A release gives one word from the back end; an allocate gives one word per
// granted block, one per cycle unless rsp_if stalls, read from the ring memory.
// A reject gives one word. A two-entry command queue sits between front and back.
// Reset is synchronous; the ring needs no clearing pass, unwritten entries
// read as their own block number via a write-fill count.
// A stalled rsp_if holds the output register, then the read stage, then the queue.
module fifo_free_block_allocator_top #(
   parameter int NUM_BLOCKS  = fba_pkg::NUM_BLOCKS_DEF,
   parameter int MAX_REQUEST = fba_pkg::MAX_REQUEST_DEF
) (
   input  wire        clock,
   input  wire        reset,
   fba_req_if.sink    req_if,
   fba_rsp_if.source  rsp_if
);

   fba_pkg::q_head_type q_head;
   logic                q_pop;

   fba_front #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .MAX_REQUEST (MAX_REQUEST)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_if),
      .q_head (q_head),
      .q_pop  (q_pop)
   );

   fba_back #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_head (q_head),
      .q_pop  (q_pop),
      .rsp    (rsp_if)
   );

endmodule

`default_nettype wire

### rtl/core/fba_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Front end: takes request words, sorts them into commands and holds them in
// a two-entry queue for the back end. Zero-count allocates are dropped here.
module fba_front #(
   parameter int NUM_BLOCKS  = fba_pkg::NUM_BLOCKS_DEF,
   parameter int MAX_REQUEST = fba_pkg::MAX_REQUEST_DEF
) (
   input  wire               clock,
   input  wire               reset,
   fba_req_if.sink           req,
   output fba_pkg::q_head_type q_head,
   input  wire               q_pop
);

   localparam int QDEPTH = 2;
   localparam int QPW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);

   fba_pkg::cmd_type          q_ff [QDEPTH];
   logic [QPW-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [QPW-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [QCW-1:0]            q_cnt_ff, q_cnt_in;

   fba_pkg::cmd_type          cmd_new;
   logic                      accept;
   logic                      push;

   // classification of the incoming word
   always_comb begin
      cmd_new.count = req.req_count;
      cmd_new.idx   = req.free_index;
      if (req.func == fba_pkg::FUNC_ALLOC) begin
         if (32'(req.req_count) > 32'(MAX_REQUEST)) begin
            cmd_new.kind = fba_pkg::CMD_SHORT;
         end else begin
            cmd_new.kind = fba_pkg::CMD_ALLOC;
         end
      end else begin
         if (32'(req.free_index) >= 32'(NUM_BLOCKS)) begin
            cmd_new.kind = fba_pkg::CMD_BADREL;
         end else begin
            cmd_new.kind = fba_pkg::CMD_REL;
         end
      end
   end

   assign req.ready = (q_cnt_ff != QCW'(QDEPTH));
   assign accept    = req.valid && req.ready;
   // an allocate of nothing gives no result
   assign push      = accept && !((req.func == fba_pkg::FUNC_ALLOC) && (req.req_count == '0));

   assign q_head.vld = (q_cnt_ff != '0);
   assign q_head.cmd = q_ff[rd_ptr_ff];

   // queue pointers and fill
   always_comb begin
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      q_cnt_in  = q_cnt_ff;
      if (push && !q_pop) begin
         q_cnt_in = q_cnt_ff + 1'b1;
      end else if (!push && q_pop) begin
         q_cnt_in = q_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         q_cnt_ff  <= q_cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

### rtl/core/fba_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Back end: owns the ring of free block numbers, pops runs of blocks for
// allocates, pushes released blocks, and drives the response words through
// a read stage and an output register.
module fba_back #(
   parameter int NUM_BLOCKS = fba_pkg::NUM_BLOCKS_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  fba_pkg::q_head_type q_head,
   output logic                q_pop,
   fba_rsp_if.source           rsp
);

`include "fifo_free_block_allocator_top_defines.svh"

   localparam int PW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CW = $clog2(NUM_BLOCKS + 1);
   localparam int IW = fba_pkg::IDX_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   // ring storage, one port each for read and write
   logic [PW-1:0] ring_mem [NUM_BLOCKS];
   logic [PW-1:0] mem_q_ff;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [CW-1:0]             fill_ff, fill_in;
   logic [PW-1:0]             head_ff, head_in;
   logic [PW-1:0]             tail_ff, tail_in;
   logic [fba_pkg::CNT_W-1:0] rem_ff, rem_in;

   // read stage
   logic                       rd_vld_ff, rd_vld_in;
   logic                       rd_ring_ff, rd_ring_in;
   logic [IW-1:0]              rd_idx_ff, rd_idx_in;
   logic [fba_pkg::STAT_W-1:0] rd_stat_ff, rd_stat_in;
   logic                       rd_last_ff, rd_last_in;
   logic [CW-1:0]              rd_tot_ff, rd_tot_in;

   // output register
   logic                       out_vld_ff, out_vld_in;
   logic [IW-1:0]              out_idx_ff;
   logic [fba_pkg::STAT_W-1:0] out_stat_ff;
   logic                       out_last_ff;
   logic [CW-1:0]              out_tot_ff;

   logic out_load;
   logic can_issue;
   logic issue;
   logic rd_en;
   logic wr_en;
   logic head_end;
   logic tail_end;

   assign out_load  = rd_vld_ff && (!out_vld_ff || rsp.ready);
   assign can_issue = !rd_vld_ff || out_load;
   assign head_end  = (head_ff == PW'(NUM_BLOCKS - 1));
   assign tail_end  = (tail_ff == PW'(NUM_BLOCKS - 1));

   // sequencer: one result word per issue
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      fill_in    = fill_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      rem_in     = rem_ff;
      q_pop      = 1'b0;
      issue      = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      rd_ring_in = 1'b0;
      rd_idx_in  = '0;
      rd_stat_in = fba_pkg::STATUS_OK;
      rd_last_in = 1'b1;
      rd_tot_in  = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_head.vld && can_issue) begin
               q_pop = 1'b1;
               issue = 1'b1;
               case (q_head.cmd.kind)
                  fba_pkg::CMD_ALLOC: begin
                     if (32'(q_head.cmd.count) > 32'(cnt_ff)) begin
                        rd_stat_in = fba_pkg::STATUS_SHORT;
                     end else begin
                        rd_en      = 1'b1;
                        rd_ring_in = (fill_ff > CW'(head_ff));
                        rd_idx_in  = IW'(head_ff);
                        rd_last_in = (q_head.cmd.count == fba_pkg::CNT_W'(1));
                        cnt_in     = cnt_ff - 1'b1;
                        rd_tot_in  = cnt_ff - 1'b1;
                        head_in    = head_end ? '0 : head_ff + 1'b1;
                        rem_in     = q_head.cmd.count - 1'b1;
                        if (q_head.cmd.count != fba_pkg::CNT_W'(1)) begin
                           state_in = ST_RUN;
                        end
                     end
                  end
                  fba_pkg::CMD_REL: begin
                     rd_idx_in = q_head.cmd.idx;
                     if (cnt_ff == CW'(NUM_BLOCKS)) begin
                        rd_stat_in = fba_pkg::STATUS_BAD_RELEASE;
                     end else begin
                        wr_en     = 1'b1;
                        cnt_in    = cnt_ff + 1'b1;
                        rd_tot_in = cnt_ff + 1'b1;
                        tail_in   = tail_end ? '0 : tail_ff + 1'b1;
                        if (fill_ff != CW'(NUM_BLOCKS)) begin
                           fill_in = fill_ff + 1'b1;
                        end
                     end
                  end
                  fba_pkg::CMD_BADREL: begin
                     rd_idx_in  = q_head.cmd.idx;
                     rd_stat_in = fba_pkg::STATUS_BAD_RELEASE;
                  end
                  default: begin
                     rd_stat_in = fba_pkg::STATUS_SHORT;
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (can_issue) begin
               issue      = 1'b1;
               rd_en      = 1'b1;
               rd_ring_in = (fill_ff > CW'(head_ff));
               rd_idx_in  = IW'(head_ff);
               rd_last_in = (rem_ff == fba_pkg::CNT_W'(1));
               cnt_in     = cnt_ff - 1'b1;
               rd_tot_in  = cnt_ff - 1'b1;
               head_in    = head_end ? '0 : head_ff + 1'b1;
               rem_in     = rem_ff - 1'b1;
               if (rem_ff == fba_pkg::CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (issue) begin
         rd_vld_in = 1'b1;
      end else if (out_load) begin
         rd_vld_in = 1'b0;
      end else begin
         rd_vld_in = rd_vld_ff;
      end
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp.ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= CW'(NUM_BLOCKS);
         fill_ff    <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         rem_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         fill_ff    <= fill_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         rem_ff     <= rem_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // ring memory; for entries past the write fill the output takes the block's own number
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[tail_ff] <= PW'(q_head.cmd.idx);
      end
      if (rd_en) begin
         mem_q_ff <= ring_mem[head_ff];
      end
   end

   // read stage and output payload
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_ring_ff <= rd_ring_in;
         rd_idx_ff  <= rd_idx_in;
         rd_stat_ff <= rd_stat_in;
         rd_last_ff <= rd_last_in;
         rd_tot_ff  <= rd_tot_in;
      end
      if (out_load) begin
         out_idx_ff  <= rd_ring_ff ? IW'(mem_q_ff) : rd_idx_ff;
         out_stat_ff <= rd_stat_ff;
         out_last_ff <= rd_last_ff;
         out_tot_ff  <= rd_tot_ff;
      end
   end

   assign rsp.valid       = out_vld_ff;
   assign rsp.block_index = out_idx_ff;
   assign rsp.status      = out_stat_ff;
   assign rsp.run_last    = out_last_ff;
   assign rsp.free_total  = fba_pkg::TOT_W'(out_tot_ff);

   // checks
   `FBA_ASSERT_IMP(a_cnt_range, 1'b1, cnt_ff <= CW'(NUM_BLOCKS), "free count beyond pool size")
   `FBA_ASSERT_IMP(a_pop_nonempty, rd_en, cnt_ff != '0, "block popped from an empty ring")
   `FBA_ASSERT_IMP(a_ptr_meet, (cnt_ff == '0) || (cnt_ff == CW'(NUM_BLOCKS)), head_ff == tail_ff, "ring pointers disagree with free count")
   `FBA_ASSERT_IMP(a_run_rem, state_ff == ST_RUN, rem_ff != '0, "run state with nothing left to grant")
   `FBA_ASSERT_NXT(a_stage_fill, issue, rd_vld_ff, "issued word lost from read stage")

endmodule

`default_nettype wire

### sim/fba_tb_pkg.sv
`timescale 1ns / 1ps

package fba_tb_pkg;

   // one expected result word
   typedef struct packed {
      logic [fba_pkg::IDX_W-1:0]  block;
      logic [fba_pkg::STAT_W-1:0] status;
      logic                       last;
      logic [fba_pkg::TOT_W-1:0]  total;
   } grant_word_type;

endpackage

### sim/fba_grant_monitor.sv
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the free ring and checks
// every result word against the oldest outstanding prediction.
module fba_grant_monitor (
   input  wire  clock,
   input  wire  reset,
   fba_req_if   req,
   fba_rsp_if   rsp,
   output int   fail_count,
   output int   pending_words
);

   localparam int NUM    = fba_pkg::NUM_BLOCKS_DEF;
   localparam int MAXREQ = fba_pkg::MAX_REQUEST_DEF;

   // shadow allocator state
   logic [fba_pkg::IDX_W-1:0]      ring [0:NUM-1];
   int                             head;
   int                             tail;
   int                             free_blocks;
   fba_tb_pkg::grant_word_type     grant_q [$];
   int                             word_no;

   initial begin
      fail_count    = 0;
      pending_words = 0;
      word_no       = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] word %0d: %s", $realtime, word_no, what);
      fail_count++;
   endtask

   function automatic fba_tb_pkg::grant_word_type make_word(input int blk,
                                                            input logic [1:0] st,
                                                            input logic last);
      fba_tb_pkg::grant_word_type w;
      w.block  = blk[fba_pkg::IDX_W-1:0];
      w.status = st;
      w.last   = last;
      w.total  = free_blocks[fba_pkg::TOT_W-1:0];
      return w;
   endfunction

   // work out the words one request gives and update the shadow ring
   task automatic predict_grants(input logic func, input int cnt, input int idx);
      int blk;
      if (func == fba_pkg::FUNC_ALLOC) begin
         if (cnt == 0) begin
            // zero request: nothing granted, no word
         end else if (cnt > MAXREQ || cnt > free_blocks) begin
            grant_q.push_back(make_word(0, fba_pkg::STATUS_SHORT, 1'b1));
         end else begin
            for (int k = 0; k < cnt; k++) begin
               blk  = ring[head];
               head = (head + 1) % NUM;
               free_blocks--;
               grant_q.push_back(make_word(blk, fba_pkg::STATUS_OK, k == cnt - 1));
            end
         end
      end else begin
         // full ring or index out of range: refused, state kept
         if (free_blocks >= NUM || idx >= NUM) begin
            grant_q.push_back(make_word(idx, fba_pkg::STATUS_BAD_RELEASE, 1'b1));
         end else begin
            ring[tail] = idx[fba_pkg::IDX_W-1:0];
            tail       = (tail + 1) % NUM;
            free_blocks++;
            grant_q.push_back(make_word(idx, fba_pkg::STATUS_OK, 1'b1));
         end
      end
   endtask

   // compare one result word with the oldest prediction
   task automatic check_word();
      fba_tb_pkg::grant_word_type got;
      fba_tb_pkg::grant_word_type want;
      got.block  = rsp.block_index;
      got.status = rsp.status;
      got.last   = rsp.run_last;
      got.total  = rsp.free_total;
      if (grant_q.size() == 0) begin
         report_mismatch($sformatf("unexpected word idx %0d status %0d last %0d total %0d",
                                   got.block, got.status, got.last, got.total));
      end else begin
         want = grant_q.pop_front();
         if (got.block !== want.block)
            report_mismatch($sformatf("block_index %0d, want %0d", got.block, want.block));
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.last !== want.last)
            report_mismatch($sformatf("run_last %0d, want %0d", got.last, want.last));
         if (got.total !== want.total)
            report_mismatch($sformatf("free_total %0d, want %0d", got.total, want.total));
      end
      word_no++;
   endtask

   // results first: a word can never stem from a request taken on the same edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM; i++)
            ring[i] = i[fba_pkg::IDX_W-1:0];
         head        = 0;
         tail        = 0;
         free_blocks = NUM;
         grant_q.delete();
      end else begin
         if (rsp.valid && rsp.ready)
            check_word();
         if (req.valid && req.ready)
            predict_grants(req.func, int'(req.req_count), int'(req.free_index));
      end
      pending_words <= grant_q.size();
   end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int RANDOM_ITEMS   = 434;
   localparam int HOLD_CYCLES    = 400;
   localparam int TAIL_CYCLES    = 50;
   localparam int WATCHDOG_LIMIT = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fba_req_if req_ch ();
   fba_rsp_if rsp_ch ();

   int  fail_count;
   int  pending_words;
   int  stalled_cycles = 0;
   bit  hold_toggle    = 1'b0;

   always #5 clock = ~clock;

   fifo_free_block_allocator_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   fba_grant_monitor u_grant_mon (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   // watchdog: too long with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver: changing stall patterns, plus one long hold on request
   initial begin
      int  mode;
      int  mode_left;
      int  stall_left;
      int  hold_left;
      int  cyc;
      bit  hold_seen;
      mode       = 0;
      mode_left  = 0;
      stall_left = 0;
      hold_left  = 0;
      cyc        = 0;
      hold_seen  = 1'b0;
      rsp_ch.ready = 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         cyc++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               2: rsp_ch.ready <= (cyc % 4) != 3;
               default: begin
                  if (stall_left == 0 && $urandom_range(0, 7) == 0)
                     stall_left = $urandom_range(1, 20);
                  if (stall_left > 0) begin
                     stall_left--;
                     rsp_ch.ready <= 1'b0;
                  end else begin
                     rsp_ch.ready <= 1'b1;
                  end
               end
            endcase
         end
         @(posedge clock);
      end
   end

   // offer one request word and wait for it to be taken
   task automatic send_word(input logic func, input int cnt, input int idx,
                            input logic last);
      req_ch.valid      <= 1'b1;
      req_ch.func       <= func;
      req_ch.req_count  <= cnt[fba_pkg::CNT_W-1:0];
      req_ch.free_index <= idx[fba_pkg::IDX_W-1:0];
      req_ch.free_last  <= last;
      do
         @(posedge clock);
      while (!req_ch.ready);
   endtask

   task automatic idle_for(input int n);
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // stop offering until every predicted word has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_words != 0);
   endtask

   // one random request word; rel_pct sets the release share
   task automatic send_random(input int rel_pct);
      int r;
      int cnt;
      if ($urandom_range(0, 99) < rel_pct) begin
         send_word(fba_pkg::FUNC_RELEASE, $urandom_range(0, 127), $urandom_range(0, 1023),
                   1'($urandom_range(0, 1)));
      end else begin
         r = $urandom_range(0, 99);
         if (r < 55)
            cnt = $urandom_range(1, 4);
         else if (r < 85)
            cnt = $urandom_range(5, 64);
         else if (r < 95)
            cnt = $urandom_range(65, 127);
         else
            cnt = 0;
         send_word(fba_pkg::FUNC_ALLOC, cnt, $urandom_range(0, 1023),
                   1'($urandom_range(0, 1)));
      end
   endtask

   // stimulus and verdict
   initial begin
      int burst_left;
      int rel_pct;
      int rel_choice [4];
      rel_choice = '{25, 50, 75, 90};
      burst_left = 0;
      rel_pct    = 50;
      req_ch.valid      = 1'b0;
      req_ch.func       = fba_pkg::FUNC_ALLOC;
      req_ch.req_count  = '0;
      req_ch.free_index = '0;
      req_ch.free_last  = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: releases into a full ring, zero and oversized requests
      send_word(fba_pkg::FUNC_RELEASE, 0, 0, 1'b0);
      send_word(fba_pkg::FUNC_RELEASE, 127, 1023, 1'b1);
      send_word(fba_pkg::FUNC_ALLOC, 0, 1023, 1'b1);
      send_word(fba_pkg::FUNC_ALLOC, 127, 0, 1'b0);
      send_word(fba_pkg::FUNC_ALLOC, 65, 0, 1'b0);
      send_word(fba_pkg::FUNC_ALLOC, 64, 0, 1'b0);
      send_word(fba_pkg::FUNC_ALLOC, 1, 0, 1'b0);
      // release, then the same block again (double release goes through)
      send_word(fba_pkg::FUNC_RELEASE, 0, 1023, 1'b1);
      send_word(fba_pkg::FUNC_RELEASE, 0, 1023, 1'b0);
      // drain to one free block; the head wraps onto released entries
      repeat (15) send_word(fba_pkg::FUNC_ALLOC, 64, 0, 1'b0);
      send_word(fba_pkg::FUNC_ALLOC, 2, 0, 1'b0);
      send_word(fba_pkg::FUNC_ALLOC, 1, 0, 1'b1);
      wait_drained();

      // random: bursts and gaps, release share changes every 40 words
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0)
            rel_pct = rel_choice[$urandom_range(0, 3)];
         if (i == 150)
            hold_toggle <= ~hold_toggle;
         if (i == 300)
            wait_drained();
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
               idle_for($urandom_range(1, 10));
         end
         burst_left--;
         send_random(rel_pct);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_words == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
